// File: hw/rtl/ecdsa_sig_der_script_builder_top_defines.svh
// Assertion macros for the checker file.
`ifndef ECDSA_SIG_DER_SCRIPT_BUILDER_TOP_DEFINES_SVH
`define ECDSA_SIG_DER_SCRIPT_BUILDER_TOP_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define EDSB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("edsb assertion failed");

// Concurrent assertion on the usual clk_i / rst_ni pair.
`define EDSB_ASSERT_STD(lbl, prop) `EDSB_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/edsb_pkg.sv
package edsb_pkg;

  // Frame layout, in input words.
  localparam logic [6:0] S_FIRST    = 7'd32;
  localparam logic [6:0] S_LAST     = 7'd63;
  localparam logic [6:0] KEY_FIRST  = 7'd64;
  localparam logic [6:0] FRAME_LAST = 7'd96;

  // Script constants.
  localparam logic [7:0] SCRIPT_LEN_OFS = 8'd74;
  localparam logic [7:0] SIG_PUSH_OFS   = 8'd39;
  localparam logic [7:0] SEQ_LEN_OFS    = 8'd36;
  localparam logic [7:0] R_LEN_BASE     = 8'd32;
  localparam logic [7:0] DER_SEQ        = 8'h30;
  localparam logic [7:0] DER_INT        = 8'h02;
  localparam logic [7:0] S_LEN          = 8'h20;
  localparam logic [7:0] PAD_BYTE       = 8'h00;
  localparam logic [7:0] SIGHASH_ALL    = 8'h01;
  localparam logic [7:0] KEY_PUSH       = 8'h21;

  // Last word index inside each queue entry.
  localparam logic [5:0] HDR_LAST_NOPAD = 6'd6;
  localparam logic [5:0] SBLK_LAST      = 6'd33;
  localparam logic [5:0] KEY0_LAST      = 6'd2;
  localparam logic [5:0] SBLK_S_OFS     = 6'd2;

  // secp256k1 group order and floor(n/2), big-endian.
  localparam logic [255:0] ORDER_N =
    256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_BAAEDCE6_AF48A03B_BFD25E8C_D0364141;
  localparam logic [255:0] HALF_N =
    256'h7FFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_5D576E73_57A4501D_DFE92F46_681B20A0;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_HDR,   // frame header, optional pad, first r word
    KIND_DATA,  // one plain word (r or key)
    KIND_SBLK,  // 0x02 0x20 and the 32 final s words
    KIND_KEY0   // sighash, key push and the first key word
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
    logic       neg;
  } entry_t;

  // Byte idx (0 = most significant) of the group order.
  function automatic logic [7:0] n_byte(input logic [4:0] idx);
    return ORDER_N[{~idx, 3'b000} +: 8];
  endfunction

  // Byte idx (0 = most significant) of half the group order.
  function automatic logic [7:0] half_byte(input logic [4:0] idx);
    return HALF_N[{~idx, 3'b000} +: 8];
  endfunction

endpackage

// File: hw/rtl/edsb_if.sv
interface edsb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface edsb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       s_negated;

  modport source (output valid, output out_byte, output out_last, output s_negated,
                  input ready);
  modport sink (input valid, input out_byte, input out_last, input s_negated,
                output ready);
endinterface

// File: hw/rtl/edsb_front.sv
module edsb_front import edsb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  edsb_in_if.sink      in_i,
  input  logic         q_full_i,
  output logic         q_push_o,
  output entry_t       q_entry_o,
  input  logic [4:0]   s_rd_idx_i,
  output logic [7:0]   s_rd_byte_o
);

  logic [6:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  s_store_q [32];
  logic [31:0] gen_q, prop_q, borrow_q;
  logic        eq_q, gt_q, neg_q;

  logic        acc, in_s, s_first, s_done;
  logic [4:0]  s_idx;
  logic [7:0]  b, n_b, h_b;
  logic        eq_prev, gt_prev, eq_new, gt_new, g_now, p_now;
  logic [31:0] gen_full, prop_full, bsum;
  logic [32:0] sum, carries;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;

  assign pos_eff = (pos_q > FRAME_LAST) ? '0 : pos_q;
  assign pos_d   = (pos_eff == FRAME_LAST) ? '0 : pos_eff + 7'd1;

  assign in_s    = (pos_eff >= S_FIRST) && (pos_eff <= S_LAST);
  assign s_idx   = pos_eff[4:0];
  assign s_first = in_s && (pos_eff == S_FIRST);
  assign s_done  = pos_eff == S_LAST;

  // Running compare against n/2, most significant word first.
  assign h_b     = half_byte(s_idx);
  assign eq_prev = s_first ? 1'b1 : eq_q;
  assign gt_prev = s_first ? 1'b0 : gt_q;
  assign gt_new  = gt_prev | (eq_prev & (b > h_b));
  assign eq_new  = eq_prev & (b == h_b);

  // Borrow generate / propagate per word for n - s; bit 0 is the last s word.
  assign n_b       = n_byte(s_idx);
  assign g_now     = b > n_b;
  assign p_now     = b == n_b;
  assign gen_full  = {gen_q[31:1], g_now};
  assign prop_full = {prop_q[31:1], p_now};
  assign bsum      = gen_full | prop_full;
  assign sum       = {1'b0, gen_full} + {1'b0, bsum};
  assign carries   = sum ^ {1'b0, gen_full} ^ {1'b0, bsum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      neg_q <= 1'b0;
    end else if (acc) begin
      pos_q <= pos_d;
      if (s_done) begin
        neg_q <= gt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_s) begin
      s_store_q[s_idx] <= b;
      gen_q[~s_idx]    <= g_now;
      prop_q[~s_idx]   <= p_now;
      eq_q             <= eq_new;
      gt_q             <= gt_new;
      if (s_done) begin
        borrow_q <= carries[31:0];
      end
    end
  end

  // Classify the word into a queue entry.
  always_comb begin
    q_entry_o.kind = KIND_DATA;
    q_entry_o.data = b;
    q_entry_o.last = 1'b0;
    q_entry_o.neg  = 1'b0;
    q_push_o       = 1'b0;
    if (pos_eff == '0) begin
      q_entry_o.kind = KIND_HDR;
      q_push_o       = acc;
    end else if (pos_eff < S_FIRST) begin
      q_push_o = acc;
    end else if (s_done) begin
      q_entry_o.kind = KIND_SBLK;
      q_entry_o.neg  = gt_new;
      q_push_o       = acc;
    end else if (pos_eff >= KEY_FIRST) begin
      q_entry_o.kind = (pos_eff == KEY_FIRST) ? KIND_KEY0 : KIND_DATA;
      q_entry_o.last = pos_eff == FRAME_LAST;
      q_entry_o.neg  = neg_q;
      q_push_o       = acc;
    end
  end

  // Final s word for the back end: stored s or n - s with the precomputed borrow.
  always_comb begin
    if (neg_q) begin
      s_rd_byte_o = n_byte(s_rd_idx_i) - s_store_q[s_rd_idx_i]
                    - {7'b0, borrow_q[~s_rd_idx_i]};
    end else begin
      s_rd_byte_o = s_store_q[s_rd_idx_i];
    end
  end

endmodule

// File: hw/rtl/edsb_fifo.sv
module edsb_fifo import edsb_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t entry_o,
  output logic   empty_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// File: hw/rtl/edsb_back.sv
module edsb_back import edsb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        q_empty_i,
  output logic        q_pop_o,
  output logic [4:0]  s_rd_idx_o,
  input  logic [7:0]  s_rd_byte_i,
  edsb_out_if.source  out_o
);

  logic [5:0] idx_q, last_idx, s_ofs;
  logic       out_valid_q, out_last_q, out_neg_q;
  logic [7:0] out_byte_q, word, len_r;
  logic       advance, load;

  assign len_r      = R_LEN_BASE + {7'b0, head_i.data[7]};
  assign s_ofs      = idx_q - SBLK_S_OFS;
  assign s_rd_idx_o = s_ofs[4:0];

  always_comb begin
    case (head_i.kind)
      KIND_HDR:  last_idx = HDR_LAST_NOPAD + {5'b0, head_i.data[7]};
      KIND_DATA: last_idx = '0;
      KIND_SBLK: last_idx = SBLK_LAST;
      KIND_KEY0: last_idx = KEY0_LAST;
      default:   last_idx = '0;
    endcase
  end

  // Pick the word for the current step of the head entry.
  always_comb begin
    word = head_i.data;
    case (head_i.kind)
      KIND_HDR: begin
        if (idx_q != last_idx) begin
          case (idx_q[2:0])
            3'd0:    word = SCRIPT_LEN_OFS + len_r;
            3'd1:    word = SIG_PUSH_OFS + len_r;
            3'd2:    word = DER_SEQ;
            3'd3:    word = SEQ_LEN_OFS + len_r;
            3'd4:    word = DER_INT;
            3'd5:    word = len_r;
            default: word = PAD_BYTE;
          endcase
        end
      end
      KIND_SBLK: begin
        if (idx_q == 6'd0) begin
          word = DER_INT;
        end else if (idx_q == 6'd1) begin
          word = S_LEN;
        end else begin
          word = s_rd_byte_i;
        end
      end
      KIND_KEY0: begin
        if (idx_q == 6'd0) begin
          word = SIGHASH_ALL;
        end else if (idx_q == 6'd1) begin
          word = KEY_PUSH;
        end
      end
      default: word = head_i.data;
    endcase
  end

  assign advance = !out_valid_q || out_o.ready;
  assign load    = advance && !q_empty_i;
  assign q_pop_o = load && (idx_q == last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      out_valid_q <= !q_empty_i;
      if (load) begin
        idx_q <= (idx_q == last_idx) ? '0 : idx_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= word;
      out_last_q <= head_i.last && (head_i.kind == KIND_DATA);
      out_neg_q  <= head_i.neg;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.out_last  = out_last_q;
  assign out_o.s_negated = out_neg_q;

endmodule

// File: hw/rtl/ecdsa_sig_der_script_builder_top.sv
// Channel | Dir | Word                      | Handshake
// in_i    | in  | in_byte (r, s, key bytes) | valid/ready
// out_o   | out | out_byte, out_last,       | valid/ready
//         |     | s_negated                 |
//
// One input word is accepted per cycle while the entry queue has room; one
// script word leaves per cycle, while the receiver is ready and entries wait,
// through a registered output stage. A frame of 97 input words yields 107 or
// 108 output words. The s words make no entry, so the back end runs dry while
// they pass.
// Reset (rst_ni low, asynchronous) clears the frame position, queue and
// output valid; output stalls fill the queue and then drop in_i.ready.
module ecdsa_sig_der_script_builder_top import edsb_pkg::*; #(
  // Must stay well below the 65 words between the last s word of one frame
  // and the first of the next, so the s store is not overwritten while read.
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  edsb_in_if.sink    in_i,
  edsb_out_if.source out_o
);

  entry_t     push_entry, head_entry;
  logic       q_push, q_pop, q_full, q_empty;
  logic [4:0] s_rd_idx;
  logic [7:0] s_rd_byte;

  // Front: track the frame position, fold s into the store, compare with n/2
  // and precompute the borrow chain for n - s; classify each word into an entry.
  edsb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry),
    .s_rd_idx_i  (s_rd_idx),
    .s_rd_byte_o (s_rd_byte)
  );

  // Short queue decoupling the input from the expanding back end.
  edsb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .empty_o (q_empty)
  );

  // Back: expand each entry into one or more script words.
  edsb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_entry),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .s_rd_idx_o  (s_rd_idx),
    .s_rd_byte_i (s_rd_byte),
    .out_o       (out_o)
  );

endmodule

// File: hw/rtl/edsb_checker.sv
`include "ecdsa_sig_der_script_builder_top_defines.svh"

module edsb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i
);

  logic [6:0] words_q;
  logic       out_acc;
  logic       first_ok;

  assign out_acc  = out_valid_i && out_ready_i;
  assign first_ok = (out_byte_i == 8'd106) || (out_byte_i == 8'd107);

  // Count accepted words since the start of the current script.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
    end else if (out_acc) begin
      if (out_last_i) begin
        words_q <= '0;
      end else if (words_q != 7'd127) begin
        words_q <= words_q + 7'd1;
      end
    end
  end

  `EDSB_ASSERT_STD(a_last_len, out_acc && out_last_i |-> words_q == 7'd106 || words_q == 7'd107)
  `EDSB_ASSERT_STD(a_no_overrun, out_acc && words_q == 7'd107 |-> out_last_i)
  `EDSB_ASSERT_STD(a_first_len, out_acc && words_q == 7'd0 |-> first_ok)
  `EDSB_ASSERT_STD(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i))

endmodule

bind ecdsa_sig_der_script_builder_top edsb_checker u_edsb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .out_last_i  (out_o.out_last)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import edsb_pkg::*;

  // Generous bound: every word waiting out the longest stall on both sides,
  // plus the two long output hold-offs.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_FRAMES = 1;

  // One expected script word.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       neg;
  } script_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Drive every block input from a known value at time zero.
  logic       in_valid = 1'b0;
  logic [7:0] in_data = 8'h00;
  logic       out_ready = 1'b0;

  edsb_in_if  in_ch ();
  edsb_out_if out_ch ();

  assign in_ch.valid   = in_valid;
  assign in_ch.in_byte = in_data;
  assign out_ch.ready  = out_ready;

  ecdsa_sig_der_script_builder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // Input words still to be offered, and script words still to arrive.
  logic [7:0]   frame_bytes[$];
  script_word_t script_expect[$];

  // Shadow of the block's frame state.
  logic [6:0]   frame_pos = 7'd0;
  logic         r_pad = 1'b0;
  logic [255:0] s_bytes = '0;

  int unsigned fail_cnt = 0;
  int unsigned words_seen = 0;
  int unsigned cycle_cnt = 0;

  // Sender pacing: gap left after the current word, and a calm stretch counter.
  int unsigned tx_gap;
  int unsigned tx_calm;

  // Receiver pacing: long hold-off, short stalls and calm stretches.
  int unsigned rx_hold;
  int unsigned rx_stall;
  int unsigned rx_calm;
  int unsigned holds_done;

  function automatic void push_word(input logic [7:0] d, input logic l, input logic n);
    script_word_t w;
    w.data = d;
    w.last = l;
    w.neg  = n;
    script_expect.push_back(w);
  endfunction

  // Work out the script words caused by one accepted frame byte.
  function automatic void script_predict(input logic [7:0] b);
    logic [7:0]   len_r;
    logic         neg;
    logic [255:0] s_fin;
    int           idx;
    // A position past the frame end cannot arise; restart at zero if it did.
    if (frame_pos > FRAME_LAST) frame_pos = 7'd0;
    if (frame_pos == 7'd0) begin
      // Header: total length, push, sequence tag and length, r tag and length.
      r_pad = b[7];
      len_r = R_LEN_BASE + {7'd0, r_pad};
      push_word(SCRIPT_LEN_OFS + len_r, 1'b0, 1'b0);
      push_word(SIG_PUSH_OFS + len_r, 1'b0, 1'b0);
      push_word(DER_SEQ, 1'b0, 1'b0);
      push_word(SEQ_LEN_OFS + len_r, 1'b0, 1'b0);
      push_word(DER_INT, 1'b0, 1'b0);
      push_word(len_r, 1'b0, 1'b0);
      if (r_pad) push_word(PAD_BYTE, 1'b0, 1'b0);
      push_word(b, 1'b0, 1'b0);
    end else if (frame_pos < S_FIRST) begin
      push_word(b, 1'b0, 1'b0);
    end else if (frame_pos <= S_LAST) begin
      // Collect s big-endian; the whole s block leaves on its last byte.
      idx = int'(frame_pos) - int'(S_FIRST);
      s_bytes[(31 - idx) * 8 +: 8] = b;
      if (frame_pos == S_LAST) begin
        neg = (s_bytes > HALF_N);
        // n - s wraps modulo 2^256 when s is above n.
        s_fin = neg ? (ORDER_N - s_bytes) : s_bytes;
        push_word(DER_INT, 1'b0, neg);
        push_word(S_LEN, 1'b0, neg);
        for (int i = 0; i < 32; i++) push_word(s_fin[(31 - i) * 8 +: 8], 1'b0, neg);
      end
    end else begin
      neg = (s_bytes > HALF_N);
      if (frame_pos == KEY_FIRST) begin
        push_word(SIGHASH_ALL, 1'b0, neg);
        push_word(KEY_PUSH, 1'b0, neg);
      end
      push_word(b, frame_pos == FRAME_LAST, neg);
    end
    frame_pos = (frame_pos == FRAME_LAST) ? 7'd0 : frame_pos + 7'd1;
  endfunction

  function automatic logic [255:0] rand256();
    logic [255:0] v;
    for (int i = 0; i < 8; i++) v[i * 32 +: 32] = $urandom;
    return v;
  endfunction

  function automatic logic [263:0] rand264();
    return {8'($urandom), rand256()};
  endfunction

  // Queue one 97-byte frame: r, s, compressed key, all big-endian.
  function automatic void add_frame(input logic [255:0] r, input logic [255:0] s,
                                    input logic [263:0] key);
    for (int i = 0; i < 32; i++) frame_bytes.push_back(r[(31 - i) * 8 +: 8]);
    for (int i = 0; i < 32; i++) frame_bytes.push_back(s[(31 - i) * 8 +: 8]);
    for (int i = 0; i < 33; i++) frame_bytes.push_back(key[(32 - i) * 8 +: 8]);
  endfunction

  // Pick the idle gap after a word: mostly none, some short, a few long.
  function automatic int unsigned next_tx_gap();
    int unsigned roll;
    if (tx_calm > 0) begin
      tx_calm = tx_calm - 1;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      tx_calm = $urandom_range(40, 120);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sender: offer queued words, hold each until taken, then idle per tx_gap.
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    logic take_next;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= 8'h00;
      tx_gap   = 0;
      tx_calm  = 0;
    end else begin
      // Predict on acceptance, before the word is replaced.
      if (in_valid && in_ch.ready) script_predict(in_data);
      take_next = !in_valid || in_ch.ready;
      if (take_next) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          in_valid <= 1'b0;
        end else if (frame_bytes.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= frame_bytes.pop_front();
          tx_gap   = next_tx_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, calm stretches, and two long hold-offs that fill
  // the entry queue while the sender keeps offering words.
  always @(posedge clk_i or negedge rst_ni) begin : drive_out
    int unsigned roll;
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      rx_hold    = 0;
      rx_stall   = 0;
      rx_calm    = 0;
      holds_done = 0;
    end else if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= (rx_hold == 0);
    end else if ((holds_done == 0 && words_seen >= 120) ||
                 (holds_done == 1 && words_seen >= 300)) begin
      holds_done = holds_done + 1;
      rx_hold    = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall = rx_stall - 1;
      out_ready <= 1'b0;
    end else if (rx_calm > 0) begin
      rx_calm = rx_calm - 1;
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        rx_calm = $urandom_range(40, 150);
        out_ready <= 1'b1;
      end else if (roll < 75) begin
        out_ready <= 1'b1;
      end else if (roll < 95) begin
        rx_stall = $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        rx_stall = $urandom_range(8, 30);
        out_ready <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken script word with the oldest expectation.
  always @(posedge clk_i) begin : check_out
    script_word_t want;
    if (rst_ni && out_ch.valid && out_ready) begin
      words_seen <= words_seen + 1;
      if (script_expect.size() == 0) begin
        fail_cnt = fail_cnt + 1;
        if (fail_cnt <= 10)
          $display("word %0d: unexpected byte %h last %b neg %b", words_seen,
                   out_ch.out_byte, out_ch.out_last, out_ch.s_negated);
      end else begin
        want = script_expect.pop_front();
        if (out_ch.out_byte !== want.data || out_ch.out_last !== want.last ||
            out_ch.s_negated !== want.neg) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10)
            $display("word %0d: expected byte %h last %b neg %b, got byte %h last %b neg %b",
                     words_seen, want.data, want.last, want.neg,
                     out_ch.out_byte, out_ch.out_last, out_ch.s_negated);
        end
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [255:0] r_val;
    logic [255:0] s_val;
    // Directed frames.
    // r all ones (padded), s exactly floor(n/2) so it stays, key all zeros.
    add_frame({256{1'b1}}, HALF_N, '0);
    // r all zeros (no pad), s one above floor(n/2) so it flips, key all ones.
    add_frame('0, HALF_N + 256'd1, {264{1'b1}});
    // r top bit clear, s all ones: n - s wraps past zero.
    add_frame({8'h7F, {248{1'b1}}}, {256{1'b1}}, rand264());

    // Random frames, each with s drawn from one of the interesting regions.
    for (int f = 0; f < RANDOM_FRAMES; f++) begin
      r_val = rand256();
      case ($urandom_range(0, 3))
        0: s_val = rand256();
        1: s_val = HALF_N - 256'd3 + 256'($urandom_range(0, 6));
        2: s_val = ORDER_N - 256'd3 + 256'($urandom_range(0, 6));
        default: begin
          s_val = rand256();
          s_val[255 -: 8] = 8'h7F;
        end
      endcase
      add_frame(r_val, s_val, rand264());
    end

    // Single reset at the start, released away from the active edge.
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for every frame byte to be taken, then for every script word.
    while (frame_bytes.size() > 0 || in_valid) @(posedge clk_i);
    while (script_expect.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
